// File: rtl/core/sliding_window_frame_time_stats_macros.svh
// assertion macros for the frame time statistics block
// used by the port checker; needs clk and rst_n in the including scope
`ifndef SLIDING_WINDOW_FRAME_TIME_STATS_MACROS_SVH
`define SLIDING_WINDOW_FRAME_TIME_STATS_MACROS_SVH

// same-cycle implication, quiet during reset
`define SWFT_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define SWFT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/swft_pkg.sv
// shared types and constants for the frame time statistics block
// no dependencies
package swft_pkg;

    localparam int TW = 16;
    localparam int DEF_WINDOW_DEPTH = 128;
    localparam int DEF_MAX_BUCKETS  = 32;

    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam logic [16:0] PCT_RESET = 17'd64881;
    localparam logic [11:0] MULT_RESET = 12'd512;
    localparam logic [5:0]  BKT_RESET = 6'd16;

    // configuration register indexes
    localparam logic [1:0] CFG_PCT  = 2'd0;
    localparam logic [1:0] CFG_MULT = 2'd1;
    localparam logic [1:0] CFG_BKT  = 2'd2;

    // cell operations
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_DEL  = 2'd1;
    localparam logic [1:0] CELL_INS  = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_HIST   = 1'b1;
    localparam logic KIND_STATS = 1'b0;
    localparam logic KIND_HIST  = 1'b1;

    typedef struct packed {
        logic [1:0]    op;
        logic          del_en;
        logic [TW-1:0] x;
        logic [TW-1:0] y;
    } cell_ctl_t;

endpackage

// File: rtl/core/swft_in_if.sv
// input word channel of the frame time statistics block
// depends on nothing
interface swft_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] frame_time;

    modport source (output valid, action, frame_time, input ready);
    modport sink (input valid, action, frame_time, output ready);
endinterface

// File: rtl/core/swft_out_if.sv
// result word channel of the frame time statistics block
// depends on nothing
interface swft_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] mean_time;
    logic [15:0] percentile_time;
    logic        stutter;
    logic [7:0]  valid_samples;
    logic [4:0]  bucket_index;
    logic [16:0] bucket_height;
    logic        last;

    modport source (output valid, result_kind, mean_time, percentile_time, stutter,
                    valid_samples, bucket_index, bucket_height, last, input ready);
    modport sink (input valid, result_kind, mean_time, percentile_time, stutter,
                  valid_samples, bucket_index, bucket_height, last, output ready);
endinterface

// File: rtl/core/swft_cell.sv
// one cell of the window chain: an arrival-order slot and a sorted slot
// depends on swft_pkg
module swft_cell (
    input  logic                        clk,
    input  swft_pkg::cell_ctl_t         ctl,
    input  logic                        valid,
    input  logic [swft_pkg::TW-1:0]     up_s,
    input  logic                        up_le,
    input  logic [swft_pkg::TW-1:0]     dn_s,
    input  logic [swft_pkg::TW-1:0]     up_w,
    output logic [swft_pkg::TW-1:0]     s,
    output logic                        le,
    output logic [swft_pkg::TW-1:0]     w
);

    logic [swft_pkg::TW-1:0] s_reg;
    logic [swft_pkg::TW-1:0] s_next;
    logic [swft_pkg::TW-1:0] w_reg;
    logic [swft_pkg::TW-1:0] w_next;
    logic                    ge;

    assign le = valid && (s_reg <= ctl.x);
    assign ge = valid && (s_reg >= ctl.y);

    always_comb
    begin
        s_next = s_reg;
        w_next = w_reg;
        unique case (ctl.op)
            swft_pkg::CELL_HOLD:
            begin
                s_next = s_reg;
            end
            swft_pkg::CELL_DEL:
            begin
                w_next = up_w;
                // when full, every cell at or above the oldest takes dn_s, closing the gap
                if (ctl.del_en && ge)
                begin
                    s_next = dn_s;
                end
            end
            swft_pkg::CELL_INS:
            begin
                if (!le)
                begin
                    s_next = up_le ? ctl.x : up_s;
                end
            end
            swft_pkg::CELL_ROT:
            begin
                s_next = dn_s;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        w_reg <= w_next;
    end

    assign s = s_reg;
    assign w = w_reg;

endmodule

// File: rtl/core/swft_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing
module swft_div #(
    parameter int NW = 24,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);

    localparam int KW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic [KW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] dq_reg, dq_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, dq_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = KW'(NW);
            dq_next   = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // dividend bits leave at the top while quotient bits enter at the bottom
            dq_next  = {dq_reg[NW-2:0], fits};
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next = cnt_reg - KW'(1);
            if (cnt_reg == KW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = dq_reg;

endmodule

// File: rtl/core/sliding_window_frame_time_stats.sv
// record word: delete, insert and prepare, then one full rotation of the sorted chain (the
// mean divider runs alongside); histogram word: a scan rotation, a counting pass over
// samples and buckets that a restore rotation completes, then, if samples differ, a divider
// run per bucket up to the last one reached; one word is worked on at a time; reset clears
// control, fill count, sum and output valid, presets the config; window slots stay undefined
// depends on swft_pkg, swft_in_if, swft_out_if, swft_cell, swft_div
module sliding_window_frame_time_stats #(
    parameter int WINDOW_DEPTH = swft_pkg::DEF_WINDOW_DEPTH,
    parameter int MAX_BUCKETS  = swft_pkg::DEF_MAX_BUCKETS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    swft_in_if.sink     req,
    swft_out_if.source  rsp
);

    localparam int TW = swft_pkg::TW;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = TW + CW;
    localparam int BW = $clog2(MAX_BUCKETS + 1);
    localparam int IW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int PW = TW + BW;
    localparam int KPW = 17 + CW;
    localparam int LW = SW + 8;
    localparam int RW = SW + 12;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DEL     = 4'd1;
    localparam logic [3:0] ST_INS     = 4'd2;
    localparam logic [3:0] ST_PREP    = 4'd3;
    localparam logic [3:0] ST_ROT     = 4'd4;
    localparam logic [3:0] ST_WAITD   = 4'd5;
    localparam logic [3:0] ST_EMIT    = 4'd6;
    localparam logic [3:0] HS_SCAN    = 4'd7;
    localparam logic [3:0] HS_SETUP   = 4'd8;
    localparam logic [3:0] HS_COUNT   = 4'd9;
    localparam logic [3:0] HS_RESTORE = 4'd10;
    localparam logic [3:0] HS_RD      = 4'd11;
    localparam logic [3:0] HS_DIV     = 4'd12;
    localparam logic [3:0] HS_WAITD   = 4'd13;
    localparam logic [3:0] HS_EMIT    = 4'd14;

    localparam logic [1:0] MD_ZERO = 2'd0;
    localparam logic [1:0] MD_SAME = 2'd1;
    localparam logic [1:0] MD_NORM = 2'd2;

    // chain wiring
    logic [TW-1:0] s_arr [WINDOW_DEPTH];
    logic [TW-1:0] w_arr [WINDOW_DEPTH];
    logic          le_arr [WINDOW_DEPTH];
    swft_pkg::cell_ctl_t ctl;

    // control
    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [16:0] pf_reg, pf_next;
    logic [11:0] sm_reg, sm_next;
    logic [5:0]  hb_reg, hb_next;
    logic        ov_reg, ov_next;

    // working registers
    logic [TW-1:0] x_reg, x_next;
    logic [CW-1:0] k_reg, k_next;
    logic [LW-1:0] lhs_reg, lhs_next;
    logic [RW-1:0] rhs_reg, rhs_next;
    logic [TW-1:0] pct_reg, pct_next;
    logic [CW-1:0] rot_reg, rot_next;
    logic [CW-1:0] t_reg, t_next;
    logic [BW-1:0] b_reg, b_next;
    logic [BW-1:0] bl_reg, bl_next;
    logic [BW-1:0] e_reg, e_next;
    logic [BW-1:0] nb_reg, nb_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] maxc_reg, maxc_next;
    logic [PW-1:0] thr_reg, thr_next;
    logic [TW-1:0] lo_reg, lo_next;
    logic [TW-1:0] hi_reg, hi_next;
    logic [1:0]    md_reg, md_next;
    logic [CW-1:0] rd_reg;
    logic [16:0]   ht_reg, ht_next;

    // output word
    logic          ok_reg, ok_next;
    logic [15:0]   om_reg, om_next;
    logic [15:0]   op_reg, op_next;
    logic          os_reg, os_next;
    logic [7:0]    ov8_reg, ov8_next;
    logic [4:0]    oi_reg, oi_next;
    logic [16:0]   oh_reg, oh_next;
    logic          ol_reg, ol_next;

    // bucket count store
    logic [CW-1:0] cnts [MAX_BUCKETS];
    logic          cw_en;
    logic [IW-1:0] cw_addr;
    logic [CW-1:0] cw_data;

    // divider
    logic          div_start;
    logic [SW-1:0] div_num;
    logic [CW-1:0] div_den;
    logic          div_busy;
    logic [SW-1:0] div_quo;

    logic [TW-1:0]  head;
    logic [TW-1:0]  oldest;
    logic           full;
    logic           out_free;
    logic [16:0]    p_clamp;
    logic [KPW-1:0] kp;
    logic [PW-1:0]  prod;
    logic           in_b;
    logic [6:0]     hbx;
    logic [BW-1:0]  nb_clamp;

    assign head     = s_arr[0];
    assign oldest   = w_arr[WINDOW_DEPTH-1];
    assign full     = n_reg == CW'(WINDOW_DEPTH);
    assign out_free = !ov_reg || rsp.ready;
    assign p_clamp  = (pf_reg > swft_pkg::Q16_ONE) ? swft_pkg::Q16_ONE : pf_reg;
    assign kp       = KPW'(p_clamp) * KPW'(n_reg - CW'(1));
    assign prod     = PW'(head - lo_reg) * PW'(nb_reg);
    assign in_b     = (b_reg == nb_reg - BW'(1)) || (prod < thr_reg);
    assign hbx      = {1'b0, hb_reg};
    assign nb_clamp = (hb_reg == 6'd0) ? BW'(1) :
                      (hbx > 7'(MAX_BUCKETS)) ? BW'(MAX_BUCKETS) : BW'(hbx);

    assign req.ready = state_reg == ST_IDLE;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_DEPTH; gi++)
        begin : g_cell
            swft_cell u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .valid (CW'(gi) < n_reg),
                .up_s  ((gi == 0) ? '0 : s_arr[(gi == 0) ? 0 : gi-1]),
                .up_le ((gi == 0) ? 1'b1 : le_arr[(gi == 0) ? 0 : gi-1]),
                .dn_s  (s_arr[(gi + 1) % WINDOW_DEPTH]),
                .up_w  ((gi == 0) ? x_reg : w_arr[(gi == 0) ? 0 : gi-1]),
                .s     (s_arr[gi]),
                .le    (le_arr[gi]),
                .w     (w_arr[gi])
            );
        end
    endgenerate

    swft_div #(
        .NW (SW),
        .DW (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        sum_next   = sum_reg;
        pf_next    = pf_reg;
        sm_next    = sm_reg;
        hb_next    = hb_reg;
        ov_next    = ov_reg;
        x_next     = x_reg;
        k_next     = k_reg;
        lhs_next   = lhs_reg;
        rhs_next   = rhs_reg;
        pct_next   = pct_reg;
        rot_next   = rot_reg;
        t_next     = t_reg;
        b_next     = b_reg;
        bl_next    = bl_reg;
        e_next     = e_reg;
        nb_next    = nb_reg;
        cnt_next   = cnt_reg;
        maxc_next  = maxc_reg;
        thr_next   = thr_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        md_next    = md_reg;
        ht_next    = ht_reg;
        ok_next    = ok_reg;
        om_next    = om_reg;
        op_next    = op_reg;
        os_next    = os_reg;
        ov8_next   = ov8_reg;
        oi_next    = oi_reg;
        oh_next    = oh_reg;
        ol_next    = ol_reg;
        ctl.op     = swft_pkg::CELL_HOLD;
        ctl.del_en = full;
        ctl.x      = x_reg;
        ctl.y      = oldest;
        cw_en      = 1'b0;
        cw_addr    = b_reg[IW-1:0];
        cw_data    = cnt_reg;
        div_start  = 1'b0;
        div_num    = sum_reg;
        div_den    = n_reg;

        if (rsp.ready)
        begin
            ov_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                swft_pkg::CFG_PCT:  pf_next = cfg_data;
                swft_pkg::CFG_MULT: sm_next = cfg_data[11:0];
                swft_pkg::CFG_BKT:  hb_next = cfg_data[5:0];
                default:            pf_next = pf_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                rot_next = '0;
                if (req.valid)
                begin
                    x_next     = req.frame_time;
                    state_next = (req.action == swft_pkg::ACT_RECORD) ? ST_DEL : HS_SCAN;
                end
            end
            ST_DEL:
            begin
                ctl.op   = swft_pkg::CELL_DEL;
                sum_next = sum_reg + SW'(x_reg) - (full ? SW'(oldest) : SW'(0));
                if (full)
                begin
                    n_next = n_reg - CW'(1);
                end
                state_next = ST_INS;
            end
            ST_INS:
            begin
                ctl.op     = swft_pkg::CELL_INS;
                n_next     = n_reg + CW'(1);
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                k_next     = kp[16 +: CW];
                lhs_next   = {SW'(x_reg) * SW'(n_reg), 8'b0};
                rhs_next   = RW'(sum_reg) * RW'(sm_reg);
                div_start  = 1'b1;
                rot_next   = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                // a full turn of the sorted chain shows every slot at the head once
                ctl.op = swft_pkg::CELL_ROT;
                if (rot_reg == k_reg)
                begin
                    pct_next = head;
                end
                rot_next = rot_reg + CW'(1);
                if (rot_reg == CW'(WINDOW_DEPTH - 1))
                begin
                    state_next = ST_WAITD;
                end
            end
            ST_WAITD:
            begin
                if (!div_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ok_next    = swft_pkg::KIND_STATS;
                    om_next    = div_quo[15:0];
                    op_next    = pct_reg;
                    os_next    = (n_reg >= CW'(2)) && (RW'(lhs_reg) > rhs_reg);
                    ov8_next   = 8'(n_reg);
                    oi_next    = '0;
                    oh_next    = '0;
                    ol_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            HS_SCAN:
            begin
                ctl.op = swft_pkg::CELL_ROT;
                if (rot_reg == '0)
                begin
                    lo_next = head;
                end
                if (rot_reg == n_reg - CW'(1))
                begin
                    hi_next = head;
                end
                rot_next = rot_reg + CW'(1);
                if (rot_reg == CW'(WINDOW_DEPTH - 1))
                begin
                    state_next = HS_SETUP;
                end
            end
            HS_SETUP:
            begin
                rot_next  = '0;
                t_next    = '0;
                b_next    = '0;
                bl_next   = '0;
                e_next    = '0;
                cnt_next  = '0;
                maxc_next = '0;
                nb_next   = nb_clamp;
                thr_next  = PW'(hi_reg - lo_reg);
                if (n_reg == '0)
                begin
                    md_next    = MD_ZERO;
                    state_next = HS_RD;
                end
                else if (hi_reg == lo_reg)
                begin
                    md_next    = MD_SAME;
                    state_next = HS_RD;
                end
                else
                begin
                    md_next    = MD_NORM;
                    state_next = HS_COUNT;
                end
            end
            HS_COUNT:
            begin
                // samples arrive in ascending order, so buckets close one after another
                if (t_reg == n_reg)
                begin
                    cw_en      = 1'b1;
                    maxc_next  = (cnt_reg > maxc_reg) ? cnt_reg : maxc_reg;
                    bl_next    = b_reg;
                    state_next = HS_RESTORE;
                end
                else if (in_b)
                begin
                    ctl.op   = swft_pkg::CELL_ROT;
                    cnt_next = cnt_reg + CW'(1);
                    t_next   = t_reg + CW'(1);
                    rot_next = rot_reg + CW'(1);
                end
                else
                begin
                    cw_en     = 1'b1;
                    maxc_next = (cnt_reg > maxc_reg) ? cnt_reg : maxc_reg;
                    b_next    = b_reg + BW'(1);
                    thr_next  = thr_reg + PW'(hi_reg - lo_reg);
                    cnt_next  = '0;
                end
            end
            HS_RESTORE:
            begin
                if (rot_reg == CW'(WINDOW_DEPTH))
                begin
                    state_next = HS_RD;
                end
                else
                begin
                    ctl.op   = swft_pkg::CELL_ROT;
                    rot_next = rot_reg + CW'(1);
                end
            end
            HS_RD:
            begin
                state_next = HS_DIV;
            end
            HS_DIV:
            begin
                if ((md_reg == MD_NORM) && (e_reg <= bl_reg))
                begin
                    div_start  = 1'b1;
                    div_num    = {rd_reg, 16'b0};
                    div_den    = maxc_reg;
                    state_next = HS_WAITD;
                end
                else
                begin
                    ht_next    = ((md_reg == MD_SAME) && (e_reg == '0)) ?
                                 swft_pkg::Q16_ONE : 17'd0;
                    state_next = HS_EMIT;
                end
            end
            HS_WAITD:
            begin
                if (!div_busy)
                begin
                    ht_next    = div_quo[16:0];
                    state_next = HS_EMIT;
                end
            end
            HS_EMIT:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    ok_next  = swft_pkg::KIND_HIST;
                    om_next  = '0;
                    op_next  = '0;
                    os_next  = 1'b0;
                    ov8_next = 8'(n_reg);
                    oi_next  = 5'(e_reg);
                    oh_next  = ht_reg;
                    ol_next  = e_reg == nb_reg - BW'(1);
                    e_next   = e_reg + BW'(1);
                    state_next = (e_reg == nb_reg - BW'(1)) ? ST_IDLE : HS_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            sum_reg   <= '0;
            pf_reg    <= swft_pkg::PCT_RESET;
            sm_reg    <= swft_pkg::MULT_RESET;
            hb_reg    <= swft_pkg::BKT_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            sum_reg   <= sum_next;
            pf_reg    <= pf_next;
            sm_reg    <= sm_next;
            hb_reg    <= hb_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        k_reg    <= k_next;
        lhs_reg  <= lhs_next;
        rhs_reg  <= rhs_next;
        pct_reg  <= pct_next;
        rot_reg  <= rot_next;
        t_reg    <= t_next;
        b_reg    <= b_next;
        bl_reg   <= bl_next;
        e_reg    <= e_next;
        nb_reg   <= nb_next;
        cnt_reg  <= cnt_next;
        maxc_reg <= maxc_next;
        thr_reg  <= thr_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        md_reg   <= md_next;
        ht_reg   <= ht_next;
        ok_reg   <= ok_next;
        om_reg   <= om_next;
        op_reg   <= op_next;
        os_reg   <= os_next;
        ov8_reg  <= ov8_next;
        oi_reg   <= oi_next;
        oh_reg   <= oh_next;
        ol_reg   <= ol_next;
    end

    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            cnts[cw_addr] <= cw_data;
        end
        rd_reg <= cnts[e_reg[IW-1:0]];
    end

    assign rsp.valid           = ov_reg;
    assign rsp.result_kind     = ok_reg;
    assign rsp.mean_time       = om_reg;
    assign rsp.percentile_time = op_reg;
    assign rsp.stutter         = os_reg;
    assign rsp.valid_samples   = ov8_reg;
    assign rsp.bucket_index    = oi_reg;
    assign rsp.bucket_height   = oh_reg;
    assign rsp.last            = ol_reg;

endmodule

// File: rtl/core/swft_chk.sv
// port checker for the frame time statistics block, bound to the top level
// depends on sliding_window_frame_time_stats_macros.svh
`include "sliding_window_frame_time_stats_macros.svh"

module swft_chk #(
    parameter int WINDOW_DEPTH = 128
) (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        result_kind,
    input logic [15:0] mean_time,
    input logic [15:0] percentile_time,
    input logic        stutter,
    input logic [7:0]  valid_samples,
    input logic [4:0]  bucket_index,
    input logic [16:0] bucket_height,
    input logic        last
);

    // a stats word is always the only word of its request
    `SWFT_ASSERT_NOW(a_stats_shape, rsp_valid && !result_kind, last && bucket_index == 5'd0 && bucket_height == 17'd0, "stats word malformed")

    `SWFT_ASSERT_NOW(a_hist_shape, rsp_valid && result_kind, mean_time == 16'd0 && percentile_time == 16'd0 && !stutter, "histogram word carries stats")

    // stutter needs at least two samples
    `SWFT_ASSERT_NOW(a_stutter_count, rsp_valid && !result_kind && stutter, valid_samples >= 8'd2, "stutter with too few samples")

    `SWFT_ASSERT_NOW(a_height_range, rsp_valid && result_kind, bucket_height <= 17'd65536, "bucket height above one")

    `SWFT_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid, "word dropped while stalled")

endmodule

bind sliding_window_frame_time_stats swft_chk #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_swft_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .result_kind     (rsp.result_kind),
    .mean_time       (rsp.mean_time),
    .percentile_time (rsp.percentile_time),
    .stutter         (rsp.stutter),
    .valid_samples   (rsp.valid_samples),
    .bucket_index    (rsp.bucket_index),
    .bucket_height   (rsp.bucket_height),
    .last            (rsp.last)
);

// File: test/tb_sliding_window_frame_time_stats.sv
// testbench for the sliding window frame time statistics block: a scoreboard class
// predicts every result word from a local window copy and checks the result stream
// depends on swft_pkg, swft_in_if, swft_out_if and the block's rtl
module tb_sliding_window_frame_time_stats;

    localparam int DEPTH = 128;
    localparam int NBMAX = 32;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        kind;
        logic [15:0] mean;
        logic [15:0] pct;
        logic        stut;
        logic [7:0]  nvalid;
        logic [4:0]  bidx;
        logic [16:0] height;
        logic        last;
    } stat_word_t;

    class frame_stats_board;
        logic [15:0] window_q[DEPTH];
        int unsigned wr_ptr;
        int unsigned fill;
        logic [16:0] pct_frac;
        logic [11:0] mult;
        logic [5:0]  nbuckets;
        stat_word_t  pending_q[$];
        int          errors;

        function new();
            wr_ptr = 0;
            fill = 0;
            pct_frac = swft_pkg::PCT_RESET;
            mult = swft_pkg::MULT_RESET;
            nbuckets = swft_pkg::BKT_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [16:0] val);
            if (idx == swft_pkg::CFG_PCT)
                pct_frac = val;
            else if (idx == swft_pkg::CFG_MULT)
                mult = val[11:0];
            else if (idx == swft_pkg::CFG_BKT)
                nbuckets = val[5:0];
        endfunction

        function void note_word(logic act, logic [15:0] ft);
            stat_word_t w;
            longint unsigned sum, lhs, rhs, p;
            int unsigned k, nb, range, b, maxc;
            logic [15:0] sorted[$];
            logic [15:0] lo, hi;
            int unsigned counts[NBMAX];
            if (act == swft_pkg::ACT_RECORD)
            begin
                window_q[wr_ptr] = ft;
                wr_ptr = (wr_ptr + 1) % DEPTH;
                if (fill < DEPTH)
                    fill++;
                sum = 0;
                for (int i = 0; i < fill; i++)
                begin
                    sum += window_q[i];
                    sorted.push_back(window_q[i]);
                end
                sorted.sort();
                p = (pct_frac > swft_pkg::Q16_ONE) ? 64'd65536 : 64'(pct_frac);
                k = 32'((p * (fill - 1)) >> 16);
                w = '0;
                w.kind = swft_pkg::KIND_STATS;
                w.mean = 16'(sum / fill);
                w.pct = sorted[k];
                lhs = 64'(ft) * 256 * fill;
                rhs = sum * mult;
                w.stut = (fill >= 2) && (lhs > rhs);
                w.nvalid = fill[7:0];
                w.last = 1'b1;
                pending_q.push_back(w);
            end
            else
            begin
                nb = (nbuckets == 6'd0) ? 1 : (nbuckets > 6'(NBMAX)) ? NBMAX : 32'(nbuckets);
                for (int i = 0; i < NBMAX; i++)
                    counts[i] = 0;
                maxc = 0;
                lo = 0;
                hi = 0;
                if (fill > 0)
                begin
                    lo = window_q[0];
                    hi = window_q[0];
                    for (int i = 1; i < fill; i++)
                    begin
                        if (window_q[i] < lo) lo = window_q[i];
                        if (window_q[i] > hi) hi = window_q[i];
                    end
                    if (hi != lo)
                    begin
                        range = 32'(hi - lo);
                        for (int i = 0; i < fill; i++)
                        begin
                            b = 32'((64'(window_q[i] - lo) * nb) / range);
                            if (b >= nb) b = nb - 1;
                            counts[b]++;
                        end
                        for (int i = 0; i < nb; i++)
                            if (counts[i] > maxc) maxc = counts[i];
                    end
                end
                for (int i = 0; i < nb; i++)
                begin
                    w = '0;
                    w.kind = swft_pkg::KIND_HIST;
                    w.nvalid = fill[7:0];
                    w.bidx = i[4:0];
                    if (fill > 0 && hi == lo)
                        w.height = (i == 0) ? swft_pkg::Q16_ONE : 17'd0;
                    else if (maxc > 0)
                        w.height = 17'((64'(counts[i]) * 65536) / maxc);
                    w.last = (i + 1 == nb);
                    pending_q.push_back(w);
                end
            end
        endfunction

        function void check_word(stat_word_t got);
            stat_word_t e;
            if (pending_q.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.kind !== e.kind)
            begin
                $error("result_kind exp %0d got %0d", e.kind, got.kind); errors++;
            end
            if (got.mean !== e.mean)
            begin
                $error("mean_time exp %0d got %0d", e.mean, got.mean); errors++;
            end
            if (got.pct !== e.pct)
            begin
                $error("percentile_time exp %0d got %0d", e.pct, got.pct); errors++;
            end
            if (got.stut !== e.stut)
            begin
                $error("stutter exp %0d got %0d", e.stut, got.stut); errors++;
            end
            if (got.nvalid !== e.nvalid)
            begin
                $error("valid_samples exp %0d got %0d", e.nvalid, got.nvalid); errors++;
            end
            if (got.bidx !== e.bidx)
            begin
                $error("bucket_index exp %0d got %0d", e.bidx, got.bidx); errors++;
            end
            if (got.height !== e.height)
            begin
                $error("bucket_height exp %0d got %0d", e.height, got.height); errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last exp %0d got %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;
    frame_stats_board board = new();

    swft_in_if  req();
    swft_out_if rsp();

    sliding_window_frame_time_stats dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL sliding_window_frame_time_stats");
            $finish;
        end
    end

    // result side: random stalls, check on every accepted word
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                board.check_word({rsp.result_kind, rsp.mean_time, rsp.percentile_time,
                                  rsp.stutter, rsp.valid_samples, rsp.bucket_index,
                                  rsp.bucket_height, rsp.last});
            rsp.ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    // valid stays up after an accepted word until the next idle cycle or drain
    task automatic send_word(logic act, logic [15:0] ft);
        while (!calm && $urandom_range(99) < 13)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.action <= act;
        req.frame_time <= ft;
        do
            @(posedge clk);
        while (!req.ready);
        board.note_word(act, ft);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(posedge clk);
        // histogram work may still trail the final word
        repeat (2 * DEPTH + 22 * NBMAX + 50)
            @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        board.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int n);
        int unsigned r;
        logic [15:0] base;
        base = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 12)
                send_word(swft_pkg::ACT_HIST, 16'($urandom));
            else if (r < 40)
                send_word(swft_pkg::ACT_RECORD, 16'($urandom));
            else if (r < 50)
                send_word(swft_pkg::ACT_RECORD,
                          {$urandom_range(1) ? 8'hff : 8'h00, 8'($urandom)});
            else
                send_word(swft_pkg::ACT_RECORD, 16'(base + $urandom_range(600)));
        end
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.action = 1'b0;
        req.frame_time = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty window histogram, then identical samples, then differing extreme ones
        send_word(swft_pkg::ACT_HIST, 16'h0);
        send_word(swft_pkg::ACT_RECORD, 16'h0000);
        send_word(swft_pkg::ACT_HIST, 16'h0);
        send_word(swft_pkg::ACT_RECORD, 16'h0000);
        send_word(swft_pkg::ACT_HIST, 16'hffff);
        send_word(swft_pkg::ACT_RECORD, 16'hffff);
        send_word(swft_pkg::ACT_RECORD, 16'h0001);
        send_word(swft_pkg::ACT_RECORD, 16'h8000);
        send_word(swft_pkg::ACT_RECORD, 16'h7fff);
        send_word(swft_pkg::ACT_HIST, 16'h0);
        drain();

        set_reg(swft_pkg::CFG_PCT, 17'h1ffff);
        set_reg(swft_pkg::CFG_MULT, 17'd0);
        set_reg(swft_pkg::CFG_BKT, 17'd0);
        set_reg(2'd3, 17'h1ffff);
        send_word(swft_pkg::ACT_RECORD, 16'd300);
        send_word(swft_pkg::ACT_HIST, 16'h0);
        drain();
        set_reg(swft_pkg::CFG_PCT, 17'd0);
        set_reg(swft_pkg::CFG_MULT, 17'd4095);
        set_reg(swft_pkg::CFG_BKT, 17'd63);
        send_word(swft_pkg::ACT_RECORD, 16'hffff);
        send_word(swft_pkg::ACT_HIST, 16'h0);
        drain();
        set_reg(swft_pkg::CFG_PCT, 17'd65536);
        set_reg(swft_pkg::CFG_BKT, 17'd32);
        send_word(swft_pkg::ACT_RECORD, 16'd5);
        send_word(swft_pkg::ACT_HIST, 16'h0);
        drain();

        // random part with a calm stretch in the middle
        set_reg(swft_pkg::CFG_PCT, swft_pkg::PCT_RESET);
        set_reg(swft_pkg::CFG_MULT, 17'(swft_pkg::MULT_RESET));
        set_reg(swft_pkg::CFG_BKT, 17'd1);
        random_phase(70);
        drain();
        set_reg(swft_pkg::CFG_PCT, 17'($urandom_range(65536)));
        set_reg(swft_pkg::CFG_MULT, 17'($urandom_range(4095)));
        set_reg(swft_pkg::CFG_BKT, 17'($urandom_range(1, 32)));
        calm = 1'b1;
        random_phase(60);
        calm = 1'b0;
        drain();
        set_reg(swft_pkg::CFG_PCT, 17'd32768);
        set_reg(swft_pkg::CFG_MULT, 17'd300);
        set_reg(swft_pkg::CFG_BKT, 17'd7);
        random_phase(70);
        drain();
        set_reg(swft_pkg::CFG_PCT, 17'h10000 | 17'($urandom));
        set_reg(swft_pkg::CFG_MULT, 17'(12'($urandom)));
        set_reg(swft_pkg::CFG_BKT, 17'(6'($urandom)));
        random_phase(60);
        drain();

        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("PASS sliding_window_frame_time_stats");
        else
            $display("FAIL sliding_window_frame_time_stats");
        $finish;
    end
endmodule

// File: sliding_window_frame_time_stats.f
+incdir+rtl/core
rtl/core/swft_pkg.sv
rtl/core/swft_in_if.sv
rtl/core/swft_out_if.sv
rtl/core/swft_cell.sv
rtl/core/swft_div.sv
rtl/core/sliding_window_frame_time_stats.sv
rtl/core/swft_chk.sv
test/tb_sliding_window_frame_time_stats.sv
